// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the sorted key table search core.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/skt_pkg.sv =====
// Package for the sorted key table search core: sizes, register map,
// transaction payload structs. Depends on nothing.
package skt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int KEY_BYTES   = 8;
  localparam int KEY_W       = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int CLEN_W      = 4;
  localparam int POS_W       = 8;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  // Register indexes, taken from paddr[2]
  localparam logic REG_ENTRY_COUNT    = 1'b0;
  localparam logic REG_COMPARE_LENGTH = 1'b1;

  // Operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [CNT_W-1:0]  CNT_RESET  = '0;
  localparam logic [CLEN_W-1:0] CLEN_RESET = CLEN_W'(KEY_BYTES);

  typedef struct packed {
    logic             operation;
    logic [7:0]       entry_index;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_item_t;

endpackage

// ===== rtl/sorted_key_table_binary_search_core.sv =====
// Sorted key table search core: key memory, binary search sequencer and
// one shared byte-wise comparator. Depends on skt_pkg and assert_macros.svh.
//
// Usage:
//   Input channel: a transaction is taken when start is high and busy is low.
//   A write transaction (operation 0) stores key at entry_index in that same
//   cycle; busy stays low and no result follows. A lookup (operation 1)
//   raises busy and runs a binary search over entries 0 to entry_count-1,
//   with entry_count clamped to 256. Each probe has two steps: the PROBE
//   state reads the memory at the middle index, then the CMP state lets the
//   shared comparator narrow the range. A lookup answers when a probe
//   matches or when the range runs out, before any probe if it is empty.
//   Result channel: out_valid is high for exactly one cycle with out_result;
//   the receiver cannot stall it. busy falls in that same cycle, so the next
//   transaction may start while the result is shown.
//   Configuration: APB-style port, entry_count at 0x0, compare_length at 0x4.
//   Write it only while busy is low.
//   Reset: entry_count clears to 0, compare_length to 8, any search is
//   dropped. Table contents are undefined until written.
`include "assert_macros.svh"

module sorted_key_table_binary_search_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  skt_pkg::in_item_t             in_item,
  output logic                          out_valid,
  output skt_pkg::out_item_t            out_result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [skt_pkg::ADDR_W-1:0]    paddr,
  input  logic [skt_pkg::DATA_W-1:0]    pwdata,
  output logic [skt_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_CMP   = 3'b100
  } state_t;

  state_t                             state_r, state_nxt;
  logic [skt_pkg::CNT_W-1:0]          entry_count_r;
  logic [skt_pkg::CLEN_W-1:0]         compare_length_r;
  logic [skt_pkg::CNT_W-1:0]          low_r, low_nxt;
  logic [skt_pkg::CNT_W-1:0]          hi_ex_r, hi_ex_nxt;
  logic [skt_pkg::CNT_W-1:0]          mid_r;
  logic [skt_pkg::KEY_W-1:0]          key_r;
  logic [skt_pkg::KEY_W-1:0]          rdata_r;
  logic                               out_valid_r, out_valid_nxt;
  skt_pkg::out_item_t                 out_result_r, out_result_nxt;

  logic [skt_pkg::KEY_W-1:0]          key_mem [skt_pkg::TABLE_DEPTH];

  logic                               accept;
  logic                               cfg_wr;
  logic [skt_pkg::CNT_W-1:0]          count_clamped;
  logic [skt_pkg::CNT_W:0]            mid_sum;
  logic [skt_pkg::CNT_W-1:0]          probe_mid;
  logic [skt_pkg::CLEN_W-1:0]         cmp_len;
  logic                               cmp_done;
  logic                               cmp_lt;
  logic                               cmp_gt;
  logic [7:0]                         byte_a;
  logic [7:0]                         byte_b;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r    <= skt_pkg::CNT_RESET;
      compare_length_r <= skt_pkg::CLEN_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        skt_pkg::REG_ENTRY_COUNT:    entry_count_r    <= pwdata[skt_pkg::CNT_W-1:0];
        skt_pkg::REG_COMPARE_LENGTH: compare_length_r <= pwdata[skt_pkg::CLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      skt_pkg::REG_ENTRY_COUNT:    prdata = skt_pkg::DATA_W'(entry_count_r);
      skt_pkg::REG_COMPARE_LENGTH: prdata = skt_pkg::DATA_W'(compare_length_r);
      default:                     prdata = '0;
    endcase
  end

  assign count_clamped = (entry_count_r > skt_pkg::CNT_W'(skt_pkg::TABLE_DEPTH)) ?
                         skt_pkg::CNT_W'(skt_pkg::TABLE_DEPTH) : entry_count_r;

  // Middle of [low, hi_ex-1]; only used while the range is not empty
  assign mid_sum   = {1'b0, low_r} + {1'b0, hi_ex_r} - 1'b1;
  assign probe_mid = mid_sum[skt_pkg::CNT_W:1];

  // Key memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && in_item.operation == skt_pkg::OP_WRITE) begin
      key_mem[in_item.entry_index[skt_pkg::IDX_W-1:0]] <= in_item.key;
    end
    if (state_r == S_PROBE) begin
      rdata_r <= key_mem[probe_mid[skt_pkg::IDX_W-1:0]];
    end
  end

  // Shared comparator: scan leading bytes, stop at first difference or
  // at a zero byte held by both keys
  assign cmp_len = (compare_length_r > skt_pkg::CLEN_W'(skt_pkg::KEY_BYTES)) ?
                   skt_pkg::CLEN_W'(skt_pkg::KEY_BYTES) : compare_length_r;

  always_comb begin
    cmp_done = 1'b0;
    cmp_lt   = 1'b0;
    cmp_gt   = 1'b0;
    byte_a   = '0;
    byte_b   = '0;
    for (int i = 0; i < skt_pkg::KEY_BYTES; i++) begin
      byte_a = rdata_r[(skt_pkg::KEY_BYTES-1-i)*8 +: 8];
      byte_b = key_r[(skt_pkg::KEY_BYTES-1-i)*8 +: 8];
      if (!cmp_done && (skt_pkg::CLEN_W'(i) < cmp_len)) begin
        if (byte_a != byte_b) begin
          cmp_done = 1'b1;
          cmp_lt   = (byte_a < byte_b);
          cmp_gt   = (byte_a > byte_b);
        end else if (byte_a == 8'd0) begin
          cmp_done = 1'b1;
        end
      end
    end
  end

  // Search sequencer
  always_comb begin
    state_nxt      = state_r;
    low_nxt        = low_r;
    hi_ex_nxt      = hi_ex_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_item.operation == skt_pkg::OP_LOOKUP) begin
          low_nxt   = '0;
          hi_ex_nxt = count_clamped;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (low_r < hi_ex_r) begin
          state_nxt = S_CMP;
        end else begin
          // exhausted range: not found
          out_valid_nxt           = 1'b1;
          out_result_nxt.found    = 1'b0;
          out_result_nxt.position = '0;
          state_nxt               = S_IDLE;
        end
      end
      S_CMP: begin
        if (cmp_lt) begin
          low_nxt   = mid_r + 1'b1;
          state_nxt = S_PROBE;
        end else if (cmp_gt) begin
          hi_ex_nxt = mid_r;
          state_nxt = S_PROBE;
        end else begin
          out_valid_nxt           = 1'b1;
          out_result_nxt.found    = 1'b1;
          out_result_nxt.position = skt_pkg::POS_W'(mid_r[skt_pkg::IDX_W-1:0]);
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r        <= low_nxt;
    hi_ex_r      <= hi_ex_nxt;
    out_result_r <= out_result_nxt;
    if (accept) begin
      key_r <= in_item.key;
    end
    if (state_r == S_PROBE) begin
      mid_r <= probe_mid;
    end
  end

  `ASSERT_CLK(a_result_after_search, out_valid_r |-> $past(busy),
              "result strobe without a search in progress")
  `ASSERT_CLK(a_mid_in_range,
              (state_r == S_CMP) |-> (mid_r >= low_r && mid_r < hi_ex_r),
              "probe index outside the search range")
  `ASSERT_NEVER(a_bound_in_table,
                busy && (hi_ex_r > skt_pkg::CNT_W'(skt_pkg::TABLE_DEPTH)),
                "search bound beyond table depth")
  `ASSERT_CLK(a_notfound_zero_pos,
              (out_valid_r && !out_result_r.found) |-> (out_result_r.position == '0),
              "not-found result with nonzero position")

endmodule

// ===== test/sorted_key_table_binary_search_core_tb.sv =====
// Testbench for sorted_key_table_binary_search_core: table writes and binary search
// lookups, checked against a behavioral search model over many register settings.
// Depends on skt_pkg and the core RTL; needs no files or arguments.
module sorted_key_table_binary_search_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 24;   // settle time after the last answer
  localparam int ITEM_TARGET    = 1950;

  logic                       clk     = 1'b0;
  logic                       rst_n   = 1'b0;
  logic                       start   = 1'b0;
  skt_pkg::in_item_t          in_item = '0;
  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [skt_pkg::ADDR_W-1:0] paddr   = '0;
  logic [skt_pkg::DATA_W-1:0] pwdata  = '0;
  logic                       busy;
  logic                       out_valid;
  skt_pkg::out_item_t         out_result;
  logic [skt_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  // Search model state, updated at the clock edge where the block takes each write
  logic [skt_pkg::KEY_W-1:0]  key_mirror [skt_pkg::TABLE_DEPTH];
  logic [skt_pkg::CNT_W-1:0]  cfg_count = skt_pkg::CNT_RESET;
  logic [skt_pkg::CLEN_W-1:0] cfg_clen  = skt_pkg::CLEN_RESET;
  skt_pkg::out_item_t         lookup_answers [$];

  // Stimulus side: table contents as the queued items will leave it
  logic [skt_pkg::KEY_W-1:0]  gen_table   [skt_pkg::TABLE_DEPTH];
  bit                         gen_written [skt_pkg::TABLE_DEPTH];
  skt_pkg::in_item_t          pending_items [$];
  int                         items_queued = 0;

  bit in_fire      = 1'b0;
  bit no_gaps      = 1'b0;
  int gap_left     = 0;
  int stall_cycles = 0;
  int errors       = 0;
  int n_writes     = 0;
  int n_lookups    = 0;
  int n_found      = 0;
  int n_settings   = 0;

  sorted_key_table_binary_search_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic skt_pkg::out_item_t search_table(input logic [skt_pkg::KEY_W-1:0] k);
    skt_pkg::out_item_t res;
    int                 lo, hi, mid, len, i, order;
    bit                 stop;
    logic [7:0]         a, b;
    res = '0;
    len = (cfg_clen > skt_pkg::KEY_BYTES) ? skt_pkg::KEY_BYTES : int'(cfg_clen);
    lo  = 0;
    hi  = ((cfg_count > skt_pkg::TABLE_DEPTH) ? skt_pkg::TABLE_DEPTH : int'(cfg_count)) - 1;
    while (lo <= hi && !res.found) begin
      mid   = (lo + hi) / 2;
      order = 0;
      stop  = 1'b0;
      for (i = 0; i < len && !stop; i++) begin
        a = key_mirror[mid][skt_pkg::KEY_W-1-8*i -: 8];
        b = k[skt_pkg::KEY_W-1-8*i -: 8];
        if (a != b) begin
          order = (a < b) ? -1 : 1;
          stop  = 1'b1;
        end else if (a == 8'h00) begin
          // both keys end here: equal regardless of later bytes
          stop = 1'b1;
        end
      end
      if (order < 0) begin
        lo = mid + 1;
      end else if (order > 0) begin
        hi = mid - 1;
      end else begin
        res.found    = 1'b1;
        res.position = skt_pkg::POS_W'(mid);
      end
    end
    return res;
  endfunction

  function automatic logic [skt_pkg::KEY_W-1:0] make_key();
    logic [skt_pkg::KEY_W-1:0] k;
    int len, i;
    k = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        len = $urandom_range(0, skt_pkg::KEY_BYTES);
        for (i = len; i < skt_pkg::KEY_BYTES; i++) k[skt_pkg::KEY_W-1-8*i -: 8] = 8'h00;
      end
      2: begin
        i = $urandom_range(0, skt_pkg::KEY_BYTES - 1);
        k[skt_pkg::KEY_W-1-8*i -: 8] = 8'h00;
      end
      default: begin
        // short strings over a tiny alphabet, so random lookups hit often
        len = $urandom_range(1, 3);
        k = '0;
        for (i = 0; i < len; i++)
          k[skt_pkg::KEY_W-1-8*i -: 8] = 8'h61 + 8'($urandom_range(0, 2));
      end
    endcase
    return k;
  endfunction

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  task automatic queue_write(input int idx, input logic [skt_pkg::KEY_W-1:0] k);
    skt_pkg::in_item_t it;
    it.operation   = skt_pkg::OP_WRITE;
    it.entry_index = 8'(idx);
    it.key         = k;
    pending_items.push_back(it);
    gen_table[idx]   = k;
    gen_written[idx] = 1'b1;
    items_queued++;
  endtask

  task automatic queue_lookup(input logic [skt_pkg::KEY_W-1:0] k);
    skt_pkg::in_item_t it;
    it.operation   = skt_pkg::OP_LOOKUP;
    it.entry_index = 8'($urandom);
    it.key         = k;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Hold until every queued transaction is taken and answered, then let the core settle
  task automatic wait_drained();
    while (pending_items.size() != 0 || start || lookup_answers.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic reg_idx, input logic [skt_pkg::DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reconfigure(input int count, input int clen);
    logic [skt_pkg::DATA_W-1:0] v;
    wait_drained();
    v = $urandom;
    v[skt_pkg::CNT_W-1:0] = skt_pkg::CNT_W'(count);
    apb_write(skt_pkg::REG_ENTRY_COUNT, v);
    v = $urandom;
    v[skt_pkg::CLEN_W-1:0] = skt_pkg::CLEN_W'(clen);
    apb_write(skt_pkg::REG_COMPARE_LENGTH, v);
    n_settings++;
  endtask

  always @(negedge clk) begin : driver
    if (rst_n && (!start || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_item  <= pending_items.pop_front();
        start    <= 1'b1;
        gap_left = no_gaps ? 0 : $urandom_range(0, 11);
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    skt_pkg::out_item_t want;
    if (!rst_n) begin
      in_fire = 1'b0;
    end else begin
      if (out_valid) begin
        if (lookup_answers.size() == 0) begin
          note_failure($sformatf("result with no lookup pending: found=%0b position=%0d",
                                 out_result.found, out_result.position));
        end else begin
          want = lookup_answers.pop_front();
          if (out_result.found !== want.found || out_result.position !== want.position)
            note_failure($sformatf("expected found=%0b position=%0d, got found=%0b position=%0d",
                                   want.found, want.position,
                                   out_result.found, out_result.position));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          skt_pkg::REG_ENTRY_COUNT:    cfg_count = pwdata[skt_pkg::CNT_W-1:0];
          skt_pkg::REG_COMPARE_LENGTH: cfg_clen  = pwdata[skt_pkg::CLEN_W-1:0];
          default: ;
        endcase
      end
      in_fire = start && !busy;
      if (in_fire) begin
        if (in_item.operation == skt_pkg::OP_WRITE) begin
          key_mirror[in_item.entry_index] = in_item.key;
          n_writes++;
        end else begin
          want = search_table(in_item.key);
          lookup_answers.push_back(want);
          n_lookups++;
          if (want.found) n_found++;
        end
      end
      if (in_fire || out_valid) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [skt_pkg::KEY_W-1:0] sorted_buf [skt_pkg::TABLE_DEPTH];
    logic [skt_pkg::KEY_W-1:0] k, t, mask;
    int n, filled, count, clen, usable, lookups, phase, i, j, r;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty range straight out of reset, then a small hand-built table
    queue_lookup(64'hFFFF_FFFF_FFFF_FFFF);
    queue_write(0, 64'h0000_0000_0000_0000);
    queue_write(1, 64'h0100_0000_0000_0000);
    queue_write(2, 64'h4100_0000_0000_0000);
    queue_write(3, 64'h4142_0000_0000_0000);
    queue_write(4, 64'h4142_4300_0000_0000);
    queue_write(5, 64'h4142_4344_4546_4748);
    queue_write(6, 64'h7F00_FF00_FF00_FF00);
    queue_write(7, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_write(255, 64'hFFFF_FFFF_FFFF_FFFF);
    reconfigure(8, 8);
    queue_lookup(64'h0000_0000_0000_0000);
    queue_lookup(64'hFFFF_FFFF_FFFF_FFFF);
    queue_lookup(64'h4142_4300_0000_0000);
    // shared zero byte ends the compare before the differing tail
    queue_lookup(64'h4142_4300_0000_0001);
    queue_lookup(64'h4142_4400_0000_0000);
    queue_lookup(64'h8000_0000_0000_0000);
    reconfigure(8, 0);
    queue_lookup(64'h1234_5678_9ABC_DEF0);
    reconfigure(8, 15);
    queue_lookup(64'h4142_4344_4546_4748);
    reconfigure(8, 1);
    queue_lookup(64'h41FF_FFFF_FFFF_FFFF);

    // Random phases: load a sorted table, pick a setting, then mostly well-formed lookups
    phase = 0;
    while (items_queued < ITEM_TARGET) begin
      n = (phase == 0 || $urandom_range(0, 11) == 0) ? skt_pkg::TABLE_DEPTH :
          $urandom_range(1, 24);
      for (i = 0; i < n; i++) begin
        k = make_key();
        j = i;
        while (j > 0 && sorted_buf[j-1] > k) begin
          sorted_buf[j] = sorted_buf[j-1];
          j--;
        end
        sorted_buf[j] = k;
      end
      for (i = 0; i < n; i++) queue_write(i, sorted_buf[i]);

      filled = 0;
      while (filled < skt_pkg::TABLE_DEPTH && gen_written[filled]) filled++;
      r = $urandom_range(0, 7);
      if (filled == skt_pkg::TABLE_DEPTH && r < 2)
        count = (r == 0) ? 511 : $urandom_range(257, 510);
      else if (r == 2) count = 0;
      else if (r == 3) count = $urandom_range(0, filled);
      else count = n;
      r = $urandom_range(0, 9);
      clen = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 15 :
             (r == 3) ? $urandom_range(2, 7) : (r == 4) ? $urandom_range(9, 14) : 8;
      no_gaps = ($urandom_range(0, 3) == 0);
      reconfigure(count, clen);

      usable  = (count > skt_pkg::TABLE_DEPTH) ? skt_pkg::TABLE_DEPTH : count;
      lookups = (n == skt_pkg::TABLE_DEPTH) ? 80 : $urandom_range(8, 40);
      for (i = 0; i < lookups; i++) begin
        r = $urandom_range(0, 99);
        t = (usable > 0) ? gen_table[$urandom_range(0, usable - 1)] : make_key();
        if (r < 55) begin
          queue_lookup(t);
        end else if (r < 65) begin
          queue_lookup(r[0] ? t + 64'd1 : t - 64'd1);
        end else if (r < 72) begin
          // keep a prefix of a stored key, scramble the rest
          mask = {skt_pkg::KEY_W{1'b1}} >> (8 * $urandom_range(1, skt_pkg::KEY_BYTES - 1));
          queue_lookup((t & ~mask) | ({$urandom, $urandom} & mask));
        end else if (r < 90) begin
          queue_lookup(make_key());
        end else begin
          queue_write($urandom_range(0, skt_pkg::TABLE_DEPTH - 1), make_key());
        end
      end
      phase++;
    end

    wait_drained();
    $display("Covered %0d table writes and %0d lookups (%0d found) over %0d register settings.",
             n_writes, n_lookups, n_found, n_settings);
    $display("Failures recorded: %0d", errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
